[rtl/vhp_pkg.sv]
// ----------------------------------------------------------------------------
// Varint header parser package
// Shared constants and types for the header parser and its submodules.
// ----------------------------------------------------------------------------
package vhp_pkg;

    localparam int BYTE_W         = 8;
    localparam int GROUP_W        = 7;
    localparam int SIZE_W         = 64;
    localparam int COUNT_W        = 4;
    localparam int POS_W          = 7;
    localparam int MAX_SIZE_BYTES = 10;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CORRUPT = 1'b1;

    typedef struct packed {
        logic              status;
        logic [SIZE_W-1:0] body_size;
        logic [BYTE_W-1:0] type_code;
    } result_t;

endpackage

[rtl/varint_header_parser.sv]
// ----------------------------------------------------------------------------
// Varint header parser
// Decodes a type byte followed by 7-bit size groups (low group first, a set top bit ends the header) into one result.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per cycle with no gaps while the output
// side does not stall. A byte is held in an input register and then folded
// into the header state by a single shift-and-merge step; the result of the
// byte that ends the header is registered in the result register or the skid
// entry before it is presented. The output side has a result register plus a
// skid entry, and input stalls only when both are occupied.
module varint_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] hdr_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] type_code, [71:8] body_size
    output logic [0:0]  m_tuser    // [0] status
);
    import vhp_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              can_push;
    logic              take;
    logic              res_valid;
    result_t           res_data;
    result_t           out_data;

    assign take = byte_valid && can_push;

    vhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    vhp_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    vhp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.body_size, out_data.type_code};
    assign m_tuser = out_data.status;

endmodule

[rtl/vhp_in_stage.sv]
// ----------------------------------------------------------------------------
// Varint header parser input stage
// Registers one stream byte and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module vhp_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [vhp_pkg::BYTE_W-1:0] s_tdata,
    input  logic                       take,
    output logic                       byte_valid,
    output logic [vhp_pkg::BYTE_W-1:0] byte_data
);
    import vhp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (take ? 1'b0 : valid_reg);
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

endmodule

[rtl/vhp_decode.sv]
// ----------------------------------------------------------------------------
// Varint header parser decoder
// Holds the header state and folds one byte into it per transfer.
// ----------------------------------------------------------------------------
module vhp_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [vhp_pkg::BYTE_W-1:0] byte_data,
    output logic                       res_valid,
    output vhp_pkg::result_t           res_data
);
    import vhp_pkg::*;

    logic               in_size_phase_reg;
    logic               in_size_phase_next;
    logic [BYTE_W-1:0]  held_type_reg;
    logic [BYTE_W-1:0]  held_type_next;
    logic [SIZE_W-1:0]  size_accum_reg;
    logic [SIZE_W-1:0]  size_accum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [POS_W-1:0]   pos;
    logic [SIZE_W-1:0]  group_shifted;
    logic [SIZE_W-1:0]  accum_or;

    assign pos       = POS_W'({3'b000, count_reg} * POS_W'(GROUP_W));
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb
    begin
        group_shifted = '0;
        if (pos < POS_W'(SIZE_W))
        begin
            group_shifted = SIZE_W'(byte_data[GROUP_W-1:0]) << pos[5:0];
        end
        accum_or = size_accum_reg | group_shifted;

        in_size_phase_next = in_size_phase_reg;
        held_type_next     = held_type_reg;
        size_accum_next    = size_accum_reg;
        count_next         = count_reg;
        res_valid          = 1'b0;
        res_data.type_code = held_type_reg;
        res_data.body_size = accum_or;
        res_data.status    = STATUS_OK;

        if (take)
        begin
            if (!in_size_phase_reg)
            begin
                held_type_next     = byte_data;
                size_accum_next    = '0;
                count_next         = '0;
                in_size_phase_next = 1'b1;
            end
            else
            begin
                size_accum_next = accum_or;
                if (byte_data[BYTE_W-1])
                begin
                    res_valid          = 1'b1;
                    in_size_phase_next = 1'b0;
                    count_next         = '0;
                end
                else if (count_inc >= COUNT_W'(MAX_SIZE_BYTES))
                begin
                    res_valid          = 1'b1;
                    res_data.body_size = '0;
                    res_data.status    = STATUS_CORRUPT;
                    in_size_phase_next = 1'b0;
                    count_next         = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_size_phase_reg <= 1'b0;
            held_type_reg     <= '0;
            size_accum_reg    <= '0;
            count_reg         <= '0;
        end
        else
        begin
            in_size_phase_reg <= in_size_phase_next;
            held_type_reg     <= held_type_next;
            size_accum_reg    <= size_accum_next;
            count_reg         <= count_next;
        end
    end

endmodule

[rtl/vhp_out_buf.sv]
// ----------------------------------------------------------------------------
// Varint header parser output buffer
// Output register with a skid entry so results keep flowing under stalls.
// ----------------------------------------------------------------------------
module vhp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vhp_pkg::result_t push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output vhp_pkg::result_t out_data
);
    import vhp_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    logic    load_out;

    assign can_push  = !skid_valid_reg;
    assign load_out  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

[rtl/vhp_checker.sv]
// ----------------------------------------------------------------------------
// Varint header parser checker
// Port-level assertions on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_corrupt_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[71:8] == 64'd0))
        else $error("Corrupted header result carries a nonzero size.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input stalled while no result is waiting.");

    a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready && m_tvalid && !m_tready) |=> !s_tready)
        else $error("Input opened while the output side stayed stalled.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("Result changed while stalled.");

endmodule

bind varint_header_parser vhp_checker u_vhp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
